// ===== hdl/gtr_pkg.sv =====
// Shared types, codes and helper functions for the graph traversal block.
package gtr_pkg;

	// Field widths of the request and result beats
	localparam int REQ_W  = 2;
	localparam int VTX_W  = 5;
	localparam int STEP_W = 6;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 6;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRAVERSAL_MODE = 2'd1;
	localparam logic [CFG_W-1:0]     VERTEX_COUNT_RST   = 6'd32;

	// Neighbor scan works on groups of this many row bits
	localparam int GRP_W  = 8;
	localparam int GRP_BW = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR = 2'd0,
		REQ_EDGE  = 2'd1,
		REQ_START = 2'd2
	} gtr_req_e_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EDGE_RA,
		ST_EDGE_WA,
		ST_EDGE_RB,
		ST_EDGE_WB,
		ST_BAD,
		ST_DFS_INIT,
		ST_DFS_POP,
		ST_DFS_CHK,
		ST_BFS_INIT,
		ST_BFS_DEQ,
		ST_BFS_CHK,
		ST_ROW_LOAD,
		ST_SCAN,
		ST_FINISH
	} gtr_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic latch;
		logic clr_graph;
		logic edge_rd_a;
		logic edge_wr_a;
		logic edge_rd_b;
		logic edge_wr_b;
		logic trav_init;
		logic bad_out;
		logic dfs_init;
		logic pop;
		logic visit;
		logic bfs_init;
		logic deq;
		logic row_rd;
		logic row_load;
		logic take;
		logic grp_step;
		logic finish;
	} gtr_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		gtr_req_e_t req;
		logic       mode;
		logic       edge_ok;
		logic       start_bad;
		logic       sp_zero;
		logic       q_empty;
		logic       cur_seen;
		logic       emit_ok;
		logic       out_free;
		logic       take_ok;
		logic       grp_hit;
		logic       grp_last;
		logic       pend_valid;
	} gtr_stat_t;

	// Position of the highest set bit of a group
	function automatic logic [GRP_BW-1:0] hi_bit8(input logic [GRP_W-1:0] v);
		logic [GRP_BW-1:0] r;
		r = '0;
		for (int i = 0; i < GRP_W; i++) begin
			if (v[i]) r = GRP_BW'(i);
		end
		return r;
	endfunction

	// Position of the lowest set bit of a group
	function automatic logic [GRP_BW-1:0] lo_bit8(input logic [GRP_W-1:0] v);
		logic [GRP_BW-1:0] r;
		r = '0;
		for (int i = GRP_W - 1; i >= 0; i--) begin
			if (v[i]) r = GRP_BW'(i);
		end
		return r;
	endfunction

endpackage

// ===== hdl/gtr_req_if.sv =====
// Request channel interface: request type and two vertex fields.
interface gtr_req_if;
	import gtr_pkg::*;

	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [VTX_W-1:0] first_vertex;
	logic [VTX_W-1:0] second_vertex;

	modport source (output valid, output req_type, output first_vertex,
		output second_vertex, input ready);
	modport sink (input valid, input req_type, input first_vertex,
		input second_vertex, output ready);
endinterface

// ===== hdl/gtr_res_if.sv =====
// Result channel interface: visited vertex, step number and flags.
interface gtr_res_if;
	import gtr_pkg::*;

	logic              valid;
	logic              ready;
	logic [VTX_W-1:0]  visited_vertex;
	logic [STEP_W-1:0] step_number;
	logic              last_visit;
	logic              bad_start;

	modport source (output valid, output visited_vertex, output step_number,
		output last_visit, output bad_start, input ready);
	modport sink (input valid, input visited_vertex, input step_number,
		input last_visit, input bad_start, output ready);
endinterface

// ===== hdl/gtr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gtr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== hdl/gtr_ctrl.sv =====
// Controller state machine: sequences requests, traversals and the result beats.
module gtr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gtr_pkg::gtr_stat_t stat,
	output gtr_pkg::gtr_cmd_t  cmd
);
	import gtr_pkg::*;

	gtr_state_t state_q;
	gtr_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (stat.req)
					REQ_EDGE: state_d = stat.edge_ok ? ST_EDGE_RA : ST_IDLE;
					REQ_START: begin
						if (stat.start_bad) state_d = ST_BAD;
						else if (stat.mode) state_d = ST_BFS_INIT;
						else state_d = ST_DFS_INIT;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_EDGE_RA: state_d = ST_EDGE_WA;
			ST_EDGE_WA: state_d = ST_EDGE_RB;
			ST_EDGE_RB: state_d = ST_EDGE_WB;
			ST_EDGE_WB: state_d = ST_IDLE;
			ST_BAD: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			ST_DFS_INIT: state_d = ST_DFS_POP;
			ST_DFS_POP: state_d = stat.sp_zero ? ST_FINISH : ST_DFS_CHK;
			ST_DFS_CHK: begin
				if (stat.cur_seen) state_d = ST_DFS_POP;
				else if (stat.emit_ok) state_d = ST_ROW_LOAD;
			end
			ST_BFS_INIT: begin
				if (stat.emit_ok) state_d = ST_BFS_DEQ;
			end
			ST_BFS_DEQ: state_d = stat.q_empty ? ST_FINISH : ST_BFS_CHK;
			ST_BFS_CHK: state_d = ST_ROW_LOAD;
			ST_ROW_LOAD: state_d = ST_SCAN;
			ST_SCAN: begin
				if (!stat.grp_hit && stat.grp_last) begin
					state_d = stat.mode ? ST_BFS_DEQ : ST_DFS_POP;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Command outputs
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.latch = in_valid;
			ST_DECODE: begin
				cmd.clr_graph = (stat.req == REQ_CLEAR);
				cmd.trav_init = (stat.req == REQ_START);
			end
			ST_EDGE_RA: cmd.edge_rd_a = 1'b1;
			ST_EDGE_WA: cmd.edge_wr_a = 1'b1;
			ST_EDGE_RB: cmd.edge_rd_b = 1'b1;
			ST_EDGE_WB: cmd.edge_wr_b = 1'b1;
			ST_BAD: cmd.bad_out = stat.out_free;
			ST_DFS_INIT: cmd.dfs_init = 1'b1;
			ST_DFS_POP: cmd.pop = !stat.sp_zero;
			ST_DFS_CHK: cmd.visit = !stat.cur_seen && stat.emit_ok;
			ST_BFS_INIT: cmd.bfs_init = stat.emit_ok;
			ST_BFS_DEQ: cmd.deq = !stat.q_empty;
			ST_BFS_CHK: cmd.row_rd = 1'b1;
			ST_ROW_LOAD: cmd.row_load = 1'b1;
			ST_SCAN: begin
				cmd.take     = stat.grp_hit && stat.take_ok;
				cmd.grp_step = !stat.grp_hit && !stat.grp_last;
			end
			ST_FINISH: cmd.finish = stat.out_free;
			default: cmd = '0;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	// A traversal always ends with a held visit to flag as the last one
	a_finish_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH |-> stat.pend_valid)
		else $error("finish without a held visit");

	// A latched request is always followed by its decode
	a_decode_after_latch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |=> state_q == ST_DECODE)
		else $error("request latch not followed by decode");

	// A visit is issued only for a vertex that is not yet marked
	a_visit_unseen: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.visit |-> !stat.cur_seen)
		else $error("visit of an already visited vertex");
endmodule

// ===== hdl/gtr_dp.sv =====
// Datapath: adjacency memory, stack, queue, visited map, scan and result registers.
module gtr_dp #(
	parameter int MAX_VERTICES = 32,
	parameter int STACK_DEPTH  = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gtr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gtr_pkg::CFG_W-1:0]      cfg_data,
	input  logic [gtr_pkg::REQ_W-1:0]      req_type,
	input  logic [gtr_pkg::VTX_W-1:0]      first_vertex,
	input  logic [gtr_pkg::VTX_W-1:0]      second_vertex,
	input  gtr_pkg::gtr_cmd_t              cmd,
	output gtr_pkg::gtr_stat_t             stat,
	input  logic                           res_ready,
	output logic                           res_valid,
	output logic [gtr_pkg::VTX_W-1:0]      visited_vertex,
	output logic [gtr_pkg::STEP_W-1:0]     step_number,
	output logic                           last_visit,
	output logic                           bad_start
);
	import gtr_pkg::*;

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int NW  = $clog2(MAX_VERTICES + 1);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int QPW = $clog2(MAX_VERTICES + 1);
	localparam int NG  = (MAX_VERTICES + GRP_W - 1) / GRP_W;
	localparam int GIW = (NG > 1) ? $clog2(NG) : 1;
	localparam int MW  = NG * GRP_W;
	localparam int NBW = GIW + GRP_BW;

	// Configuration registers
	logic [CFG_W-1:0] vcount_q;
	logic             mode_q;

	// Latched request
	logic [REQ_W-1:0] req_q;
	logic [VTX_W-1:0] a_q;
	logic [VTX_W-1:0] b_q;

	// Traversal state
	logic [MAX_VERTICES-1:0] row_ok_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [STEP_W-1:0]       cnt_q;
	logic [SPW-1:0]          sp_q;
	logic [QPW-1:0]          head_q;
	logic [QPW-1:0]          tail_q;
	logic [MW-1:0]           mask_q;
	logic [GIW-1:0]          grp_q;
	logic                    rd_ok_q;

	// Held visit and result register
	logic              pend_valid_q;
	logic [VW-1:0]     pend_vtx_q;
	logic [STEP_W-1:0] pend_step_q;
	logic              out_valid_q;
	logic [VTX_W-1:0]  out_vtx_q;
	logic [STEP_W-1:0] out_step_q;
	logic              out_last_q;
	logic              out_bad_q;

	logic [NW-1:0]           n_val;
	logic [MAX_VERTICES-1:0] ltn;
	logic [VW-1:0]           a_idx;
	logic [VW-1:0]           b_idx;
	logic [VW-1:0]           cur_idx;
	logic [VW-1:0]           s_rd;
	logic [VW-1:0]           q_rd;
	logic [MAX_VERTICES-1:0] adj_rd;
	logic [MAX_VERTICES-1:0] adj_row;
	logic                    adj_re;
	logic [VW-1:0]           adj_raddr;
	logic                    adj_we;
	logic [VW-1:0]           adj_waddr;
	logic [VW-1:0]           adj_obit;
	logic [MAX_VERTICES-1:0] adj_wdata;
	logic                    s_we;
	logic [SAW-1:0]          s_waddr;
	logic [VW-1:0]           s_wdata;
	logic [SPW-1:0]          sp_m1;
	logic                    sp_full;
	logic                    q_we;
	logic [VW-1:0]           q_waddr;
	logic [VW-1:0]           q_wdata;
	logic                    q_full;
	logic [GRP_W-1:0]        grp_bits;
	logic [GRP_BW-1:0]       bitpos;
	logic [NBW-1:0]          nb_full;
	logic [VW-1:0]           nb;
	logic                    emit_en;
	logic [VW-1:0]           emit_vtx;
	logic [STEP_W-1:0]       step_next;
	logic                    out_free;
	logic                    emit_ok;

	// Effective vertex count and the mask of vertices in use
	always_comb begin
		n_val = (32'(vcount_q) >= MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcount_q);
		for (int i = 0; i < MAX_VERTICES; i++) begin
			ltn[i] = (32'(i) < 32'(n_val));
		end
	end

	assign a_idx   = VW'(a_q);
	assign b_idx   = VW'(b_q);
	assign cur_idx = mode_q ? q_rd : s_rd;
	assign adj_row = rd_ok_q ? adj_rd : '0;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VERTEX_COUNT_RST;
			mode_q   <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_VERTEX_COUNT) vcount_q <= cfg_data;
			if (cfg_index == REG_TRAVERSAL_MODE) mode_q <= cfg_data[0];
		end
	end

	// Capture the request beat
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req_type;
			a_q   <= first_vertex;
			b_q   <= second_vertex;
		end
	end

	// Adjacency memory: row read, read-modify-write for edges
	assign adj_re    = cmd.edge_rd_a | cmd.edge_rd_b | cmd.visit | cmd.row_rd;
	assign adj_raddr = cmd.edge_rd_a ? a_idx : (cmd.edge_rd_b ? b_idx : cur_idx);
	assign adj_we    = cmd.edge_wr_a | cmd.edge_wr_b;
	assign adj_waddr = cmd.edge_wr_a ? a_idx : b_idx;
	assign adj_obit  = cmd.edge_wr_a ? b_idx : a_idx;
	assign adj_wdata = adj_row | ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << adj_obit);

	gtr_ram #(
		.WIDTH(MAX_VERTICES),
		.DEPTH(MAX_VERTICES)
	) u_adj_ram (
		.clk  (clk),
		.we   (adj_we),
		.waddr(adj_waddr),
		.wdata(adj_wdata),
		.re   (adj_re),
		.raddr(adj_raddr),
		.rdata(adj_rd)
	);

	// Row valid bits: a row never written since the last clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
		end else if (cmd.clr_graph) begin
			row_ok_q <= '0;
		end else if (adj_we) begin
			row_ok_q[adj_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adj_re) rd_ok_q <= row_ok_q[adj_raddr];
	end

	// Neighbor scan over one group of the candidate mask
	assign grp_bits = mask_q[grp_q*GRP_W +: GRP_W];
	assign bitpos   = mode_q ? lo_bit8(grp_bits) : hi_bit8(grp_bits);
	assign nb_full  = {grp_q, bitpos};
	assign nb       = VW'(nb_full);

	always_ff @(posedge clk) begin
		if (cmd.row_load) begin
			mask_q <= MW'(adj_row & ~visited_q & ltn);
			grp_q  <= mode_q ? '0 : GIW'(NG - 1);
		end else if (cmd.take) begin
			mask_q <= mask_q & ~({{(MW-1){1'b0}}, 1'b1} << nb_full);
		end else if (cmd.grp_step) begin
			grp_q <= mode_q ? grp_q + 1'b1 : grp_q - 1'b1;
		end
	end

	// Pending stack
	assign sp_m1   = sp_q - SPW'(1);
	assign sp_full = (sp_q == SPW'(STACK_DEPTH));
	assign s_we    = cmd.dfs_init | (cmd.take & !mode_q & !sp_full);
	assign s_waddr = cmd.dfs_init ? '0 : sp_q[SAW-1:0];
	assign s_wdata = cmd.dfs_init ? a_idx : nb;

	gtr_ram #(
		.WIDTH(VW),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (s_we),
		.waddr(s_waddr),
		.wdata(s_wdata),
		.re   (cmd.pop),
		.raddr(sp_m1[SAW-1:0]),
		.rdata(s_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sp_q <= '0;
		else if (cmd.dfs_init) sp_q <= SPW'(1);
		else if (cmd.pop) sp_q <= sp_m1;
		else if (s_we) sp_q <= sp_q + SPW'(1);
	end

	// Pending queue
	assign q_full  = (tail_q == QPW'(MAX_VERTICES));
	assign q_we    = cmd.bfs_init | (cmd.take & mode_q & !q_full);
	assign q_waddr = cmd.bfs_init ? '0 : VW'(tail_q);
	assign q_wdata = cmd.bfs_init ? a_idx : nb;

	gtr_ram #(
		.WIDTH(VW),
		.DEPTH(MAX_VERTICES)
	) u_queue_ram (
		.clk  (clk),
		.we   (q_we),
		.waddr(q_waddr),
		.wdata(q_wdata),
		.re   (cmd.deq),
		.raddr(VW'(head_q)),
		.rdata(q_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (cmd.bfs_init) begin
			head_q <= '0;
			tail_q <= QPW'(1);
		end else begin
			if (cmd.deq) head_q <= head_q + QPW'(1);
			if (q_we) tail_q <= tail_q + QPW'(1);
		end
	end

	// Visit: mark, count and hold until the next visit shows it is not the last
	assign emit_en   = cmd.visit | cmd.bfs_init | (cmd.take & mode_q & !q_full);
	assign emit_vtx  = cmd.visit ? s_rd : (cmd.bfs_init ? a_idx : nb);
	assign step_next = cnt_q + STEP_W'(1);
	assign out_free  = !out_valid_q || res_ready;
	assign emit_ok   = !pend_valid_q || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q    <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
		end else if (cmd.trav_init) begin
			visited_q <= '0;
			cnt_q     <= '0;
		end else if (emit_en) begin
			visited_q[emit_vtx] <= 1'b1;
			cnt_q               <= step_next;
			pend_valid_q        <= 1'b1;
		end else if (cmd.finish) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			pend_vtx_q  <= emit_vtx;
			pend_step_q <= step_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.bad_out || cmd.finish || (emit_en && pend_valid_q)) out_valid_q <= 1'b1;
		else if (res_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.bad_out) begin
			out_vtx_q  <= '0;
			out_step_q <= '0;
			out_last_q <= 1'b1;
			out_bad_q  <= 1'b1;
		end else if (cmd.finish || (emit_en && pend_valid_q)) begin
			out_vtx_q  <= VTX_W'(pend_vtx_q);
			out_step_q <= pend_step_q;
			out_last_q <= cmd.finish;
			out_bad_q  <= 1'b0;
		end
	end

	assign res_valid      = out_valid_q;
	assign visited_vertex = out_vtx_q;
	assign step_number    = out_step_q;
	assign last_visit     = out_last_q;
	assign bad_start      = out_bad_q;

	// Status to the controller
	always_comb begin
		stat            = '0;
		stat.req        = gtr_req_e_t'(req_q);
		stat.mode       = mode_q;
		stat.edge_ok    = (32'(a_q) < 32'(n_val)) && (32'(b_q) < 32'(n_val));
		stat.start_bad  = (32'(a_q) >= 32'(n_val));
		stat.sp_zero    = (sp_q == '0);
		stat.q_empty    = (head_q == tail_q);
		stat.cur_seen   = visited_q[s_rd];
		stat.emit_ok    = emit_ok;
		stat.out_free   = out_free;
		stat.take_ok    = !mode_q || q_full || emit_ok;
		stat.grp_hit    = (grp_bits != '0);
		stat.grp_last   = mode_q ? (grp_q == GIW'(NG - 1)) : (grp_q == '0);
		stat.pend_valid = pend_valid_q;
	end

	// A held visit moves to the result register only when that register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit_en && pend_valid_q |-> out_free)
		else $error("held visit pushed onto a stalled result");

	// Stack pointer and queue indexes stay within their storage
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q && tail_q <= QPW'(MAX_VERTICES))
		else $error("queue indexes out of order");

	// A bad-start result is always the last of its traversal
	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_bad_q |-> out_last_q)
		else $error("bad start result without last mark");
endmodule

// ===== hdl/graph_traversal_bfs_dfs.sv =====
// Top level of the adjacency-matrix graph traversal block (depth- and breadth-first).
//
//   channel  dir  handshake      beat contents
//   req      in   valid/ready    req_type, first_vertex, second_vertex
//   res      out  valid/ready    visited_vertex, step_number, last_visit, bad_start
//   cfg      in   cfg_we only    cfg_index, cfg_data (0 vertex_count, 1 traversal_mode)
//
// Add edge does two read-modify-writes on the adjacency RAM, each waiting on its registered
// read. A traversal scans NG = ceil(MAX_VERTICES/8) row groups per visited vertex and takes
// its unvisited neighbors one per cycle, unless a stalled result port holds them in
// breadth-first mode; in depth-first mode each stale stack entry is popped and checked too.
// Reset is asynchronous and clears the graph through per-row valid bits, no sweep.
// A stalled result port holds the traversal; the final result sits in the output
// register while the next request is taken.
module graph_traversal_bfs_dfs #(
	parameter int MAX_VERTICES = 32,
	parameter int STACK_DEPTH  = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gtr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gtr_pkg::CFG_W-1:0]     cfg_data,
	gtr_req_if.sink                       req,
	gtr_res_if.source                     res
);
	import gtr_pkg::*;

	gtr_cmd_t  cmd;
	gtr_stat_t stat;

	// Controller
	gtr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// Datapath
	gtr_dp #(
		.MAX_VERTICES(MAX_VERTICES),
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.req_type      (req.req_type),
		.first_vertex  (req.first_vertex),
		.second_vertex (req.second_vertex),
		.cmd           (cmd),
		.stat          (stat),
		.res_ready     (res.ready),
		.res_valid     (res.valid),
		.visited_vertex(res.visited_vertex),
		.step_number   (res.step_number),
		.last_visit    (res.last_visit),
		.bad_start     (res.bad_start)
	);
endmodule
